[sv/jmpc_pkg.sv]
package jmpc_pkg;

  // Default sizes of the solver.
  localparam int unsigned HORIZON_DEF = 15;
  localparam int unsigned JOINTS_DEF  = 7;

  // Widths of the shared arithmetic units.
  localparam int MUL_AW = 128;
  localparam int MUL_BW = 64;
  localparam int DIV_NW = 128;
  localparam int DIV_DW = 64;

  // Fixed widths that follow from the item fields.
  localparam int VMW = 51;  // torque_limit shifted by 20 bits
  localparam int CW  = 47;  // predicted cost

  localparam logic [15:0]    PW_RESET   = 16'd100;
  localparam logic [16:0]    POS_EXTRA  = 17'd50000;
  localparam logic [23:0]    WDQ_BASE   = 24'd40000;
  localparam logic [23:0]    WDQ_LAST   = 24'd12040000;
  localparam logic [CW-1:0]  COST_MAX   = {CW{1'b1}};

  // The cost scale is 2^30 * 5^8. After the shift by 30 the quotient by 5^8 comes
  // from a product with floor(2^80 / 5^8).
  localparam logic [18:0]    COST_DIV5  = 19'd390625;
  localparam logic [63:0]    COST_RECIP = 64'd3094850098213450687;

  // Multiplier operations issued by the controller.
  typedef enum logic [3:0] {
    MOP_NX,
    MOP_NY,
    MOP_DS2,
    MOP_DS,
    MOP_XX,
    MOP_XW,
    MOP_YY,
    MOP_YW,
    MOP_VV,
    MOP_VW,
    MOP_CR
  } mop_e;

  // Divider operand selection.
  typedef enum logic [1:0] {
    DSEL_VMAX,
    DSEL_NUM
  } dsel_e;

  typedef struct packed {
    logic  load;
    logic  init;
    logic  step_next;
    logic  prep;
    logic  mul_start;
    logic  mul_acc;
    mop_e  op;
    logic  div_start;
    dsel_e dsel;
    logic  vmax_capture;
    logic  vset;
    logic  cost_init;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic last_step;
  } sts_t;

endpackage

[sv/joint_mpc_accel_solver_unit.sv]
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o  joint_index_i, position_i, velocity_i,
//                                               ref_position_i, ref_velocity_i,
//                                               ref_accel_i, inertia_i, torque_limit_i
// result    out        out_valid_o / out_stall_i joint_tag_o, accel_cmd_o, predicted_cost_o
// config    in         cfg_valid_i / cfg_ready_o cfg_data_i (position weight)
//
// One item at a time. Each product of both horizon passes runs through one
// bit-serial shift-and-add multiplier. A 128-step division for the torque bound
// overlaps the first pass, a second one for the ratio follows it, and the cost
// is scaled by a reciprocal product.
// Reset is asynchronous and active low; it restores the position weight to 100 and
// clears every kept joint acceleration. A stalled result stays in the output register
// while the next item is already taken and worked on.
module joint_mpc_accel_solver_unit import jmpc_pkg::*; #(
  parameter int unsigned HORIZON = HORIZON_DEF,
  parameter int unsigned JOINTS  = JOINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         joint_index_i,
  input  logic signed [31:0] position_i,
  input  logic signed [31:0] velocity_i,
  input  logic signed [31:0] ref_position_i,
  input  logic signed [31:0] ref_velocity_i,
  input  logic signed [31:0] ref_accel_i,
  input  logic [30:0]        inertia_i,
  input  logic [30:0]        torque_limit_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         joint_tag_o,
  output logic signed [31:0] accel_cmd_o,
  output logic [CW-1:0]      predicted_cost_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Ready each cycle; user must write the weight register only while idle (unchecked).
  assign cfg_ready_o = 1'b1;

  // The controller sequences the horizon passes: for each step it prepares the
  // error and weight terms, then issues the products one after another to the
  // shared multiplier. The torque bound division overlaps the first pass.
  jmpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the exact 128-bit numerator and cost sums, the kept
  // accelerations and the output register.
  jmpc_datapath #(
    .HORIZON(HORIZON),
    .JOINTS (JOINTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .joint_index_i   (joint_index_i),
    .position_i      (position_i),
    .velocity_i      (velocity_i),
    .ref_position_i  (ref_position_i),
    .ref_velocity_i  (ref_velocity_i),
    .ref_accel_i     (ref_accel_i),
    .inertia_i       (inertia_i),
    .torque_limit_i  (torque_limit_i),
    .joint_tag_o     (joint_tag_o),
    .accel_cmd_o     (accel_cmd_o),
    .predicted_cost_o(predicted_cost_o)
  );

endmodule

[sv/jmpc_mul.sv]
module jmpc_mul import jmpc_pkg::*; #(
  parameter int AW = MUL_AW,
  parameter int BW = MUL_BW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic          done_o,
  output logic [AW-1:0] prod_o
);

  // Shift-and-add multiplier, one multiplier bit a cycle, product modulo 2^AW.
  logic [AW-1:0] a_q;
  logic [BW-1:0] b_q;
  logic [AW-1:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (start_i) begin
      b_q <= b_i;
    end else if (b_q != '0) begin
      b_q <= b_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= '0;
    end else if (b_q != '0) begin
      if (b_q[0]) begin
        p_q <= p_q + a_q;
      end
      a_q <= a_q << 1;
    end
  end

  assign done_o = (b_q == '0);
  assign prod_o = p_q;

endmodule

[sv/jmpc_div.sv]
module jmpc_div import jmpc_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  // Restoring divider, one quotient bit a cycle. The divisor stays below 2^(DW-1).
  localparam int CNW = $clog2(NW + 1);

  logic [CNW-1:0] cnt_q;
  logic [NW-1:0]  n_q;
  logic [DW-1:0]  rem_q;
  logic [DW-1:0]  d_q;
  logic [DW-1:0]  rsh;
  logic           ge;

  assign rsh = {rem_q[DW-2:0], n_q[NW-1]};
  assign ge  = (rsh >= d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= n_i;
      d_q   <= d_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? rsh - d_q : rsh;
      n_q   <= {n_q[NW-2:0], ge};
    end
  end

  assign done_o = (cnt_q == '0);
  assign quo_o  = n_q;

endmodule

[sv/jmpc_ctrl.sv]
module jmpc_ctrl import jmpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_STEP,
    ST_PREP,
    ST_GO,
    ST_WAIT,
    ST_NDIV,
    ST_NWAIT,
    ST_VSET,
    ST_CINIT,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  mop_e   op_q, op_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.op    = op_q;
    cmd_o.dsel  = DSEL_VMAX;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init      = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.dsel      = DSEL_VMAX;
        op_d            = MOP_NX;
        state_d         = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step_next = 1'b1;
        state_d         = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_GO;
      end
      ST_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.mul_acc = 1'b1;
          state_d       = ST_GO;
          case (op_q)
            MOP_NX:  op_d = MOP_NY;
            MOP_NY:  op_d = MOP_DS2;
            MOP_DS2: op_d = MOP_DS;
            MOP_DS: begin
              if (sts_i.last_step) begin
                state_d = ST_NDIV;
              end else begin
                op_d    = MOP_NX;
                state_d = ST_STEP;
              end
            end
            MOP_XX:  op_d = MOP_XW;
            MOP_XW:  op_d = MOP_YY;
            MOP_YY:  op_d = MOP_YW;
            MOP_YW: begin
              if (sts_i.last_step) begin
                op_d = MOP_VV;
              end else begin
                op_d    = MOP_XX;
                state_d = ST_STEP;
              end
            end
            MOP_VV:  op_d = MOP_VW;
            MOP_VW:  op_d = MOP_CR;
            MOP_CR:  state_d = ST_FIN;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_NDIV: begin
        if (sts_i.div_done) begin
          cmd_o.vmax_capture = 1'b1;
          cmd_o.div_start    = 1'b1;
          cmd_o.dsel         = DSEL_NUM;
          state_d            = ST_NWAIT;
        end
      end
      ST_NWAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_VSET;
        end
      end
      ST_VSET: begin
        cmd_o.vset = 1'b1;
        state_d    = ST_CINIT;
      end
      ST_CINIT: begin
        cmd_o.cost_init = 1'b1;
        op_d            = MOP_XX;
        state_d         = ST_STEP;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= MOP_NX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[sv/jmpc_datapath.sv]
module jmpc_datapath import jmpc_pkg::*; #(
  parameter int unsigned HORIZON = HORIZON_DEF,
  parameter int unsigned JOINTS  = JOINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [2:0]         joint_index_i,
  input  logic signed [31:0] position_i,
  input  logic signed [31:0] velocity_i,
  input  logic signed [31:0] ref_position_i,
  input  logic signed [31:0] ref_velocity_i,
  input  logic signed [31:0] ref_accel_i,
  input  logic [30:0]        inertia_i,
  input  logic [30:0]        torque_limit_i,
  output logic [2:0]         joint_tag_o,
  output logic signed [31:0] accel_cmd_o,
  output logic [CW-1:0]      predicted_cost_o
);

  localparam int SW   = $clog2(HORIZON + 1);
  localparam int S2W  = 2 * SW;
  localparam int AW   = 33;
  localparam int SAW  = AW + SW;
  localparam int S2AW = AW + S2W;
  localparam int SEDW = 41 + SW;
  localparam int EQKW = 48;
  localparam int EDKW = 40;
  localparam int XM   = (S2AW > SEDW) ? S2AW : SEDW;
  localparam int XW   = ((XM > EQKW) ? XM : EQKW) + 2;
  localparam int YW   = ((SAW > EDKW) ? SAW : EDKW) + 1;
  localparam int WQW  = 17;
  localparam int WS2W = WQW + S2W;
  localparam int WDW  = 24;
  localparam int WYW  = WDW + SW;

  localparam logic [SW-1:0]     H_S      = SW'(HORIZON);
  localparam logic signed [29:0] NUM0K_S = 30'(4000000 * HORIZON);
  localparam logic [63:0]       NUM0K_U  = 64'(4000000 * HORIZON);
  localparam logic [63:0]       DEN0     = 64'(12000000 * HORIZON);

  logic [15:0]        pw_q;
  logic signed [31:0] last_q [JOINTS];

  logic [2:0]         joint_q;
  logic               ok_q;
  logic signed [32:0] eq_q, edq_q;
  logic signed [AW-1:0] a_q;
  logic signed [31:0] vp_q;
  logic [30:0]        inertia_q, tl_q;

  logic signed [EQKW-1:0] eqk_q;
  logic signed [40:0]     edq200_q;
  logic signed [EDKW-1:0] edq100_q;

  logic [SW-1:0]          s_q;
  logic [S2W-1:0]         s2_q;
  logic signed [SAW-1:0]  sa_q;
  logic signed [S2AW-1:0] s2a_q;
  logic signed [SEDW-1:0] sedq_q;

  logic signed [XW-1:0] x_q;
  logic signed [YW-1:0] y_q;
  logic [WS2W-1:0]      ws2_q;
  logic [WYW-1:0]       wy_q;

  logic [MUL_AW-1:0] num_q, t_q;
  logic [63:0]       den_q;
  logic [VMW-1:0]    vmax_q;
  logic signed [31:0] v_q;

  logic [2:0]         tag_q;
  logic signed [31:0] accel_q;
  logic [CW-1:0]      cost_q;

  logic signed [31:0] vp_rd;
  logic               joint_ok;
  logic               last_step;
  logic [WQW-1:0]     wq_s;
  logic [WDW-1:0]     wdqk;
  logic [XW-1:0]      absx;
  logic [YW-1:0]      absy;
  logic signed [32:0] dv;
  logic [32:0]        absdv;
  logic signed [61:0] vpk;

  logic              mul_done;
  logic [MUL_AW-1:0] mul_a, prod;
  logic [MUL_BW-1:0] mul_b;
  logic              div_done;
  logic [DIV_NW-1:0] div_n, quo;
  logic [DIV_DW-1:0] div_d;

  logic               over;
  logic [VMW-1:0]     mm;
  logic signed [31:0] v_new;

  logic [47:0]        cq0;
  logic [65:0]        cqd;
  logic [65:0]        crem;
  logic [48:0]        cq;
  logic               csat;

  always_comb begin
    vp_rd = '0;
    for (int k = 0; k < JOINTS; k++) begin
      if ({1'b0, joint_index_i} == 4'(k)) begin
        vp_rd = last_q[k];
      end
    end
  end

  assign joint_ok  = (32'(joint_index_i) < JOINTS);
  assign last_step = (s_q == H_S);
  assign wq_s      = WQW'(pw_q) + (last_step ? POS_EXTRA : '0);
  assign wdqk      = last_step ? WDQ_LAST : WDQ_BASE;
  assign absx      = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
  assign absy      = y_q[YW-1] ? YW'(-y_q) : YW'(y_q);
  assign dv        = 33'(v_q) - 33'(vp_q);
  assign absdv     = dv[32] ? 33'(-dv) : 33'(dv);
  assign vpk       = vp_q * NUM0K_S;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      MOP_NX: begin
        mul_a = MUL_AW'(x_q);
        mul_b = MUL_BW'(ws2_q);
      end
      MOP_NY: begin
        mul_a = MUL_AW'(y_q);
        mul_b = MUL_BW'(wy_q);
      end
      MOP_DS2: begin
        mul_a = MUL_AW'(ws2_q);
        mul_b = MUL_BW'(s2_q);
      end
      MOP_DS: begin
        mul_a = MUL_AW'(wy_q);
        mul_b = MUL_BW'(s_q);
      end
      MOP_XX: begin
        mul_a = MUL_AW'(absx);
        mul_b = MUL_BW'(absx);
      end
      MOP_XW: begin
        mul_a = prod;
        mul_b = MUL_BW'(wq_s);
      end
      MOP_YY: begin
        mul_a = MUL_AW'(absy);
        mul_b = MUL_BW'(absy);
      end
      MOP_YW: begin
        mul_a = prod;
        mul_b = MUL_BW'(wdqk);
      end
      MOP_VV: begin
        mul_a = MUL_AW'(absdv);
        mul_b = MUL_BW'(absdv);
      end
      MOP_VW: begin
        mul_a = prod;
        mul_b = NUM0K_U;
      end
      MOP_CR: begin
        mul_a = MUL_AW'(t_q[MUL_AW-1:30]);
        mul_b = COST_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.dsel)
      DSEL_VMAX: begin
        div_n = DIV_NW'({tl_q, 20'd0});
        div_d = (inertia_q == '0) ? DIV_DW'(1) : DIV_DW'(inertia_q);
      end
      DSEL_NUM: begin
        div_n = num_q[MUL_AW-1] ? -num_q : num_q;
        div_d = den_q;
      end
      default: begin
        div_n = '0;
        div_d = DIV_DW'(1);
      end
    endcase
  end

  jmpc_mul #(
    .AW(MUL_AW),
    .BW(MUL_BW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (prod)
  );

  jmpc_div #(
    .NW(DIV_NW),
    .DW(DIV_DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .n_i    (div_n),
    .d_i    (div_d),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // Magnitude is clamped to vmax first, then to the 32-bit range of its sign.
  assign over = (quo[DIV_NW-1:VMW] != '0) || (quo[VMW-1:0] > vmax_q);
  assign mm   = over ? vmax_q : quo[VMW-1:0];

  always_comb begin
    if (!num_q[MUL_AW-1]) begin
      v_new = (mm > VMW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(mm);
    end else begin
      v_new = (mm >= VMW'(33'h0_8000_0000)) ? 32'sh8000_0000 : -32'(mm);
    end
  end

  // The cost is the sum divided by 2^30 * 5^8. The reciprocal product gives the
  // quotient or one below it, and the remainder test adds the missing one. A sum
  // at or above 2^96 always saturates.
  assign cq0  = prod[MUL_AW-1:80];
  assign cqd  = 66'(cq0) * 66'(COST_DIV5);
  assign crem = t_q[95:30] - cqd;
  assign cq   = 49'(cq0) + ((crem >= 66'(COST_DIV5)) ? 49'd1 : 49'd0);
  assign csat = (t_q[MUL_AW-1:96] != '0) || (cq[48:CW] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q <= PW_RESET;
      for (int k = 0; k < JOINTS; k++) begin
        last_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        pw_q <= cfg_data_i;
      end
      for (int k = 0; k < JOINTS; k++) begin
        if (cmd_i.cost_init && ok_q && ({1'b0, joint_q} == 4'(k))) begin
          last_q[k] <= v_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      joint_q   <= joint_index_i;
      ok_q      <= joint_ok;
      eq_q      <= 33'(ref_position_i) - 33'(position_i);
      edq_q     <= 33'(ref_velocity_i) - 33'(velocity_i);
      a_q       <= AW'(ref_accel_i);
      vp_q      <= joint_ok ? vp_rd : '0;
      inertia_q <= inertia_i;
      tl_q      <= torque_limit_i;
    end
    if (cmd_i.init) begin
      eqk_q    <= EQKW'(eq_q) * 48'sd20000;
      edq200_q <= 41'(edq_q) * 41'sd200;
      edq100_q <= EDKW'(edq_q) * 40'sd100;
      num_q    <= MUL_AW'(vpk);
      den_q    <= DEN0;
      t_q      <= '0;
    end
    if (cmd_i.init || cmd_i.cost_init) begin
      s_q    <= '0;
      s2_q   <= '0;
      sa_q   <= '0;
      s2a_q  <= '0;
      sedq_q <= '0;
    end else if (cmd_i.step_next) begin
      s_q    <= s_q + 1'b1;
      s2_q   <= s2_q + S2W'({s_q, 1'b1});
      sa_q   <= sa_q + SAW'(a_q);
      s2a_q  <= s2a_q + S2AW'(sa_q) + S2AW'(sa_q) + S2AW'(a_q);
      sedq_q <= sedq_q + SEDW'(edq200_q);
    end
    if (cmd_i.cost_init) begin
      a_q <= a_q - AW'(v_q);
    end
    if (cmd_i.prep) begin
      x_q   <= XW'(eqk_q) + XW'(sedq_q) + XW'(s2a_q);
      y_q   <= YW'(edq100_q) + YW'(sa_q);
      ws2_q <= WS2W'(wq_s) * WS2W'(s2_q);
      wy_q  <= WYW'(wdqk) * WYW'(s_q);
    end
    if (cmd_i.mul_acc) begin
      case (cmd_i.op)
        MOP_NX, MOP_NY:          num_q <= num_q + prod;
        MOP_DS2, MOP_DS:         den_q <= den_q + prod[63:0];
        MOP_XW, MOP_YW, MOP_VW:  t_q   <= t_q + prod;
        default:                 t_q   <= t_q;
      endcase
    end
    if (cmd_i.vmax_capture) begin
      vmax_q <= quo[VMW-1:0];
    end
    if (cmd_i.vset) begin
      v_q <= v_new;
    end
    if (cmd_i.out_load) begin
      tag_q   <= joint_q;
      accel_q <= v_q;
      cost_q  <= csat ? COST_MAX : cq[CW-1:0];
    end
  end

  assign sts_o.mul_done  = mul_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.last_step = last_step;

  assign joint_tag_o      = tag_q;
  assign accel_cmd_o      = accel_q;
  assign predicted_cost_o = cost_q;

endmodule

[tb/tb_joint_mpc_accel_solver_unit.sv]
module tb_joint_mpc_accel_solver_unit;
  import jmpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog is sized for the slowest item with every gap and stall added,
  // several times over.
  localparam int unsigned CYCLE_LIMIT  = 25_000_000;
  localparam int unsigned LONG_HOLD    = 8000;
  localparam int unsigned RANDOM_ITEMS = 145;

  // One joint sample, laid out as the block's input fields.
  typedef struct {
    logic [2:0]         joint;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] rpos;
    logic signed [31:0] rvel;
    logic signed [31:0] racc;
    logic [30:0]        inertia;
    logic [30:0]        tlim;
  } joint_sample_t;

  // One acceleration command, laid out as the block's result fields.
  typedef struct {
    logic [2:0]         joint;
    logic signed [31:0] accel;
    logic [CW-1:0]      cost;
  } accel_cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         joint_index_i = '0;
  logic signed [31:0] position_i = '0;
  logic signed [31:0] velocity_i = '0;
  logic signed [31:0] ref_position_i = '0;
  logic signed [31:0] ref_velocity_i = '0;
  logic signed [31:0] ref_accel_i = '0;
  logic [30:0]        inertia_i = '0;
  logic [30:0]        torque_limit_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic [2:0]         joint_tag_o;
  logic signed [31:0] accel_cmd_o;
  logic [CW-1:0]      predicted_cost_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [15:0]        cfg_data_i = '0;

  joint_mpc_accel_solver_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .joint_index_i    (joint_index_i),
    .position_i       (position_i),
    .velocity_i       (velocity_i),
    .ref_position_i   (ref_position_i),
    .ref_velocity_i   (ref_velocity_i),
    .ref_accel_i      (ref_accel_i),
    .inertia_i        (inertia_i),
    .torque_limit_i   (torque_limit_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .joint_tag_o      (joint_tag_o),
    .accel_cmd_o      (accel_cmd_o),
    .predicted_cost_o (predicted_cost_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  // Predictor state: the position weight and the acceleration kept per joint.
  logic [15:0]        pos_weight = PW_RESET;
  logic signed [31:0] kept_accel [JOINTS_DEF];

  joint_sample_t samples_to_send [$];
  accel_cmd_t    commands_due [$];
  joint_sample_t sample_on_bus;

  int unsigned idle_in_pct  = 0;
  int unsigned idle_out_pct = 0;
  int unsigned mismatches   = 0;
  int unsigned samples_sent = 0;
  int unsigned cmds_checked = 0;
  int unsigned cycles       = 0;
  int unsigned hold_left    = 0;
  int unsigned clamped_cmds = 0;
  bit          hold_arm     = 1'b0;
  bit          hold_used    = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Works out the command for one sample with exact wide arithmetic and updates
  // the kept acceleration of the joint when the index names a real joint.
  function automatic accel_cmd_t solve_joint(joint_sample_t smp);
    logic signed [127:0] vp, eq, edq, acc, num, den, x, y, wq, wdq, ss;
    logic signed [127:0] v, vmax, divisor, av, e, d, t, dv, cost;
    accel_cmd_t cmd;
    bit ok;
    ok  = smp.joint < JOINTS_DEF;
    vp  = 0;
    if (ok) vp = kept_accel[smp.joint];
    eq  = smp.rpos;
    eq  = eq - smp.pos;
    edq = smp.rvel;
    edq = edq - smp.vel;
    acc = smp.racc;
    num = vp * 128'sd4000000 * HORIZON_DEF;
    den = 128'sd12000000 * HORIZON_DEF;
    for (int s = 1; s <= HORIZON_DEF; s++) begin
      ss  = s;
      wq  = {112'b0, pos_weight};
      wdq = 1;
      if (s == HORIZON_DEF) begin
        wq  = wq + 50000;
        wdq = 301;
      end
      x   = 20000 * eq + 200 * ss * edq + ss * ss * acc;
      y   = 100 * edq + ss * acc;
      num = num + x * wq * ss * ss + y * 40000 * wdq * ss;
      den = den + wq * ss * ss * ss * ss + 40000 * wdq * ss * ss;
    end
    // Signed division truncates toward zero, as the block does.
    v       = num / den;
    divisor = (smp.inertia == '0) ? 128'sd1 : {97'b0, smp.inertia};
    vmax    = {97'b0, smp.tlim};
    vmax    = (vmax <<< 20) / divisor;
    if (v > vmax || v < -vmax) clamped_cmds++;
    if (v > vmax) v = vmax;
    if (v < -vmax) v = -vmax;
    if (v > 128'sd2147483647) v = 128'sd2147483647;
    if (v < -128'sd2147483648) v = -128'sd2147483648;
    if (ok) kept_accel[smp.joint] = v[31:0];

    // Cost of the horizon simulated with the chosen acceleration.
    av = acc - v;
    t  = 0;
    for (int s = 1; s <= HORIZON_DEF; s++) begin
      ss  = s;
      wq  = {112'b0, pos_weight};
      wdq = 1;
      if (s == HORIZON_DEF) begin
        wq  = wq + 50000;
        wdq = 301;
      end
      e = 20000 * eq + 200 * ss * edq + ss * ss * av;
      d = 100 * edq + ss * av;
      t = t + e * e * wq + d * d * 40000 * wdq;
    end
    dv   = v - vp;
    t    = t + dv * dv * 128'sd4000000 * HORIZON_DEF;
    cost = t / (128'sd400000000 <<< 20);
    if (cost > {81'b0, COST_MAX}) cost = {81'b0, COST_MAX};
    cmd.joint = smp.joint;
    cmd.accel = v[31:0];
    cmd.cost  = cost[CW-1:0];
    return cmd;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (command %0d)", what, got, want,
             cmds_checked);
  endtask

  task automatic queue_sample(logic [2:0] j, logic signed [31:0] p, logic signed [31:0] v,
                              logic signed [31:0] rp, logic signed [31:0] rv,
                              logic signed [31:0] ra, logic [30:0] inr, logic [30:0] tl);
    joint_sample_t smp;
    smp = '{j, p, v, rp, rv, ra, inr, tl};
    samples_to_send.push_back(smp);
  endtask

  // Most samples look like a real joint: modest errors, a plausible inertia and
  // limit. The rest are raw noise over the whole field range.
  task automatic queue_random_sample();
    logic [2:0] j;
    j = $urandom_range(9) == 0 ? 3'd7 : 3'($urandom_range(JOINTS_DEF - 1));
    if ($urandom_range(99) < 78) begin
      queue_sample(j, $signed(32'($urandom_range(1 << 23))) - (1 << 22),
                   $signed(32'($urandom_range(1 << 22))) - (1 << 21),
                   $signed(32'($urandom_range(1 << 23))) - (1 << 22),
                   $signed(32'($urandom_range(1 << 22))) - (1 << 21),
                   $signed(32'($urandom_range(1 << 24))) - (1 << 23),
                   31'($urandom_range(1 << 22, 1 << 16)),
                   31'($urandom_range(1 << 28, 1 << 18)));
    end else begin
      queue_sample(j, $urandom, $urandom, $urandom, $urandom, $urandom,
                   31'($urandom_range(3) == 0 ? 0 : $urandom),
                   31'($urandom));
    end
  endtask

  // Both queues empty means the block is idle and the weight may change.
  task automatic wait_drained();
    while (samples_to_send.size() != 0 || commands_due.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_weight(logic [15:0] w);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    pos_weight = w;
    cfg_valid_i <= 1'b0;
  endtask

  // Driver: a new sample goes on the bus only once the previous transfer has
  // completed, and the prediction is made at the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        commands_due.push_back(solve_joint(sample_on_bus));
        samples_sent++;
      end
      if (samples_to_send.size() != 0 && $urandom_range(99) >= idle_in_pct) begin
        sample_on_bus   = samples_to_send.pop_front();
        joint_index_i  <= sample_on_bus.joint;
        position_i     <= sample_on_bus.pos;
        velocity_i     <= sample_on_bus.vel;
        ref_position_i <= sample_on_bus.rpos;
        ref_velocity_i <= sample_on_bus.rvel;
        ref_accel_i    <= sample_on_bus.racc;
        inertia_i      <= sample_on_bus.inertia;
        torque_limit_i <= sample_on_bus.tlim;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks every result transfer and drives the stall, including one
  // long hold-off that lets the block fill and push back on its input.
  always @(posedge clk_i or negedge rst_ni) begin
    accel_cmd_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (commands_due.size() == 0) begin
          report_mismatch("unexpected result", joint_tag_o, 0);
        end else begin
          want = commands_due.pop_front();
          if (joint_tag_o !== want.joint)
            report_mismatch("joint_tag", joint_tag_o, want.joint);
          if (accel_cmd_o !== want.accel)
            report_mismatch("accel_cmd", accel_cmd_o, want.accel);
          if (predicted_cost_o !== want.cost)
            report_mismatch("predicted_cost", predicted_cost_o, want.cost);
        end
        cmds_checked++;
      end
      if (hold_arm && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LONG_HOLD;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < idle_out_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles,
               commands_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [15:0] weights [6];
    for (int j = 0; j < JOINTS_DEF; j++) kept_accel[j] = '0;
    weights = '{PW_RESET, 16'd0, 16'hFFFF, 16'($urandom), 16'd1, 16'($urandom)};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed samples: field extremes, the unclamped and fully clamped cases,
    // zero inertia, zero torque limit, an index beyond the last joint, and a
    // joint revisited so that its kept acceleration matters.
    queue_sample(3'd0, 0, 0, 0, 0, 0, 31'h0010_0000, 31'h7FFF_FFFF);
    queue_sample(3'd0, 0, 0, 32'h0010_0000, 0, 0, 31'h0010_0000, 31'h7FFF_FFFF);
    queue_sample(3'd0, 0, 0, 32'h0010_0000, 0, 0, 31'h0010_0000, 31'h7FFF_FFFF);
    queue_sample(3'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 31'h0, 31'h7FFF_FFFF);
    queue_sample(3'd2, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 31'h0, 31'h7FFF_FFFF);
    queue_sample(3'd3, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF, 31'h1);
    queue_sample(3'd4, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                 31'h0010_0000, 31'h0);
    queue_sample(3'd5, 32'h0000_1000, 0, 0, 0, 32'hFFF0_0000, 31'h7FFF_FFFF,
                 31'h7FFF_FFFF);
    queue_sample(3'd6, 0, 0, 32'h0040_0000, 32'h0020_0000, 32'h0008_0000,
                 31'h0020_0000, 31'h0100_0000);
    queue_sample(3'd7, 0, 0, 32'h0040_0000, 0, 0, 31'h0010_0000, 31'h7FFF_FFFF);
    queue_sample(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'h8000_0000, 31'h1,
                 31'h7FFF_FFFF);
    queue_sample(3'd1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF,
                 32'h0000_0001, 31'h1, 31'h1);
    queue_sample(3'd6, 0, 0, 32'h0040_0000, 32'h0020_0000, 32'h0008_0000,
                 31'h0020_0000, 31'h0100_0000);
    queue_sample(3'd2, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555);

    // Six phases, each with its own weight; three idling patterns repeat in turn. The first
    // keeps the weight from reset; the others write the register while idle.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) write_weight(weights[ph]);
      case (ph % 3)
        0: begin
          idle_in_pct  = 32;
          idle_out_pct = 76;
        end
        1: begin
          idle_in_pct  = 76;
          idle_out_pct = 32;
        end
        default: begin
          idle_in_pct  = 0;
          idle_out_pct = 0;
        end
      endcase
      // With the sender never idling, a long hold-off on the result side
      // backs the block up into its input.
      if (ph == 2) hold_arm = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) queue_random_sample();
      wait_drained();
    end

    $display("%0d joint samples sent, %0d commands checked, %0d clamped by the limit",
             samples_sent, cmds_checked, clamped_cmds);
    $display("weights 0, 1, 100, 65535 and random; stalls on both sides and one long hold");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
